### design/alr_pkg.sv
// alr_pkg: shared types, codes and constants of the antialiased line rasterizer
// used by alr_ctrl, alr_dp and antialiased_line_rasterizer_unit; no dependencies
`default_nettype none
package alr_pkg;

  localparam int COORD_BITS    = 10;
  localparam int FRAC_BITS_DEF = 16;

  // input command codes
  localparam logic CMD_LINE  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // framebuffer access codes
  localparam logic ACC_WRITE = 1'b0;
  localparam logic ACC_READ  = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [7:0]            line_red;
    logic [7:0]            line_green;
    logic [7:0]            line_blue;
    logic [7:0]            bg_red;
    logic [7:0]            bg_green;
    logic [7:0]            bg_blue;
  } alr_in_t;

  typedef struct packed {
    logic                  access;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [7:0]            out_red;
    logic [7:0]            out_green;
    logic [7:0]            out_blue;
    logic                  line_done;
    logic                  last_of_item;
  } alr_out_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_UPPER,
    PH_LOWER
  } alr_phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_START_WR,
    ST_DIV,
    ST_INIT,
    ST_NEXT,
    ST_BLEND,
    ST_PIX_WR,
    ST_RD_LOWER,
    ST_ADV
  } alr_state_t;

  typedef enum logic [1:0] {
    EM_START,
    EM_PIXEL,
    EM_LOWER,
    EM_NEXT
  } alr_emit_t;

  typedef struct packed {
    logic      capture;
    logic      setup;
    logic      div_start;
    logic      init;
    logic      blend_step;
    logic      emit;
    alr_emit_t emit_kind;
    logic      advance;
  } alr_cmd_t;

  typedef struct packed {
    logic in_is_line;
    logic line_busy;
    logic slot_free;
    logic div_done;
    logic blend_last;
    logic lower_ok;
  } alr_status_t;

endpackage
`default_nettype wire

### design/antialiased_line_rasterizer_unit.sv
// Wu-style antialiased line rasterizer. A line command is taken in one transfer; the unit
// then writes the solid start pixel, divides once for the slope (one quotient bit per cycle)
// and issues either the first read request or the solid end write. Each background pixel
// returned for a read is blended one colour channel per cycle against the line colour, and
// no next item is taken before it has given the blended write and the next read request
// or the end write. Results leave through a one-deep output register, so the next item
// is accepted while the last result of an item still waits for out_ready.
// Straddling pixels past the coordinate range are skipped, and a new line command abandons
// any line in progress.
// depends on alr_pkg, alr_ctrl, alr_dp, alr_div
`default_nettype none
module antialiased_line_rasterizer_unit #(
  parameter int FRAC_BITS = alr_pkg::FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire alr_pkg::alr_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output alr_pkg::alr_out_t      out_data
);

  alr_pkg::alr_cmd_t    cmd;
  alr_pkg::alr_status_t sts;

  alr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  alr_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### design/alr_ctrl.sv
// alr_ctrl: sequencing state machine of the line rasterizer
// depends on alr_pkg; drives alr_dp through alr_cmd_t and reads alr_status_t
`default_nettype none
module alr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire alr_pkg::alr_status_t sts,
  output alr_pkg::alr_cmd_t         cmd
);

  alr_pkg::alr_state_t state_r, state_nxt;
  logic                in_fire;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= alr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      alr_pkg::ST_IDLE: begin
        if (in_fire) begin
          priority if (sts.in_is_line) state_nxt = alr_pkg::ST_SETUP;
          else if (sts.line_busy)      state_nxt = alr_pkg::ST_BLEND;
          else                         state_nxt = alr_pkg::ST_IDLE;
        end
      end
      alr_pkg::ST_SETUP:    state_nxt = alr_pkg::ST_START_WR;
      alr_pkg::ST_START_WR: if (sts.slot_free) state_nxt = alr_pkg::ST_DIV;
      alr_pkg::ST_DIV:      if (sts.div_done) state_nxt = alr_pkg::ST_INIT;
      alr_pkg::ST_INIT:     state_nxt = alr_pkg::ST_NEXT;
      alr_pkg::ST_NEXT:     if (sts.slot_free) state_nxt = alr_pkg::ST_IDLE;
      alr_pkg::ST_BLEND:    if (sts.blend_last) state_nxt = alr_pkg::ST_PIX_WR;
      alr_pkg::ST_PIX_WR: begin
        if (sts.slot_free) begin
          state_nxt = sts.lower_ok ? alr_pkg::ST_RD_LOWER : alr_pkg::ST_ADV;
        end
      end
      alr_pkg::ST_RD_LOWER: if (sts.slot_free) state_nxt = alr_pkg::ST_IDLE;
      alr_pkg::ST_ADV:      state_nxt = alr_pkg::ST_NEXT;
      default:              state_nxt = alr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      alr_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_fire;
      end
      alr_pkg::ST_SETUP: cmd.setup = 1'b1;
      alr_pkg::ST_START_WR: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = alr_pkg::EM_START;
        // kick the slope division once, together with the start pixel transfer
        cmd.div_start = sts.slot_free;
      end
      alr_pkg::ST_DIV:  cmd = '0;
      alr_pkg::ST_INIT: cmd.init = 1'b1;
      alr_pkg::ST_NEXT: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = alr_pkg::EM_NEXT;
      end
      alr_pkg::ST_BLEND: cmd.blend_step = 1'b1;
      alr_pkg::ST_PIX_WR: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = alr_pkg::EM_PIXEL;
      end
      alr_pkg::ST_RD_LOWER: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = alr_pkg::EM_LOWER;
      end
      alr_pkg::ST_ADV: cmd.advance = 1'b1;
      default:         cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

### design/alr_div.sv
// alr_div: restoring divider, one quotient bit per cycle
// no package dependencies; used by alr_dp for the line slope
`default_nettype none
module alr_div #(
  parameter int DW = 26,
  parameter int VW = 10
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic      [DW-1:0] quotient
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;
  logic          q_bit;

  assign rem_sh  = {rem_r, dvd_r[DW-1]};
  assign q_bit   = (rem_sh >= {1'b0, divisor});
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // quotient bits shift in where the dividend bits leave
      dvd_nxt = {dvd_r[DW-2:0], q_bit};
      rem_nxt = q_bit ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule
`default_nettype wire

### design/alr_dp.sv
// alr_dp: line geometry, slope, stepping, channel blend and result register
// depends on alr_pkg and alr_div; controlled by alr_ctrl
`default_nettype none
module alr_dp #(
  parameter int FRAC_BITS = alr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire alr_pkg::alr_in_t     in_data,
  input  wire alr_pkg::alr_cmd_t    cmd,
  output alr_pkg::alr_status_t      sts,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output alr_pkg::alr_out_t         out_data
);

  localparam int C  = alr_pkg::COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int MW = C + F + 2;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  alr_pkg::alr_in_t    in_r;
  alr_pkg::alr_phase_t phase_r, phase_nxt;
  logic                xdom_r;
  logic [C-1:0]        maj_start_r;
  logic [C-1:0]        major_stop_r;
  logic [C-1:0]        mi_start_r;
  logic [C-1:0]        dmaj_r;
  logic [C-1:0]        dmin_abs_r;
  logic                dmin_neg_r;
  logic [C:0]          major_pos_r;
  logic signed [MW-1:0] minor_r;
  logic signed [F+1:0] slope_r;
  logic [2*C-1:0]      end_point_r;
  logic [23:0]         colour_r;
  logic [1:0]          ch_r;
  logic [2:0][7:0]     blend_r;
  logic                out_valid_r;
  alr_pkg::alr_out_t   out_data_r;

  // ---------------- setup geometry
  logic [C-1:0] adx, ady, ma1, ma2, mi1, mi2, s_ma1, s_ma2, s_mi1, s_mi2;
  logic         xdom_c, swap_c;

  always_comb begin
    adx    = (in_r.x_end >= in_r.x_start) ? in_r.x_end - in_r.x_start
                                          : in_r.x_start - in_r.x_end;
    ady    = (in_r.y_end >= in_r.y_start) ? in_r.y_end - in_r.y_start
                                          : in_r.y_start - in_r.y_end;
    xdom_c = adx > ady;
    ma1    = xdom_c ? in_r.x_start : in_r.y_start;
    ma2    = xdom_c ? in_r.x_end   : in_r.y_end;
    mi1    = xdom_c ? in_r.y_start : in_r.x_start;
    mi2    = xdom_c ? in_r.y_end   : in_r.x_end;
    swap_c = ma2 < ma1;
    s_ma1  = swap_c ? ma2 : ma1;
    s_ma2  = swap_c ? ma1 : ma2;
    s_mi1  = swap_c ? mi2 : mi1;
    s_mi2  = swap_c ? mi1 : mi2;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.setup) begin
      xdom_r       <= xdom_c;
      maj_start_r  <= s_ma1;
      major_stop_r <= s_ma2;
      mi_start_r   <= s_mi1;
      dmaj_r       <= s_ma2 - s_ma1;
      dmin_neg_r   <= s_mi2 < s_mi1;
      dmin_abs_r   <= (s_mi2 >= s_mi1) ? s_mi2 - s_mi1 : s_mi1 - s_mi2;
      end_point_r  <= {in_r.y_end, in_r.x_end};
      colour_r     <= {in_r.line_red, in_r.line_green, in_r.line_blue};
    end
  end

  // ---------------- slope division
  logic           div_done;
  logic [C+F-1:0] div_quot;

  alr_div #(
    .DW(C + F),
    .VW(C)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({dmin_abs_r, {F{1'b0}}}),
    .divisor  (dmaj_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  // ---------------- minor position
  logic [MW-2:0] minor_pos;
  logic [C-1:0]  m_int;
  logic [F-1:0]  m_frac;
  logic [F+1:0]  slope_mag;
  logic [F+1:0]  slope_c;

  // a negative minor position reads as zero
  assign minor_pos = minor_r[MW-1] ? '0 : minor_r[MW-2:0];
  assign m_int     = minor_pos[F+C-1:F];
  assign m_frac    = minor_pos[F-1:0];
  assign slope_mag = {1'b0, div_quot[F:0]};
  assign slope_c   = (dmaj_r == '0) ? '0 : (dmin_neg_r ? -slope_mag : slope_mag);

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      slope_r     <= slope_c;
      major_pos_r <= {1'b0, maj_start_r} + (C+1)'(1);
      minor_r     <= $signed({2'b00, mi_start_r, {F{1'b0}}})
                     + $signed({{C{slope_c[F+1]}}, slope_c});
    end else if (cmd.advance) begin
      major_pos_r <= {1'b0, major_pos_r[C-1:0] + C'(1)};
      minor_r     <= minor_r + $signed({{C{slope_r[F+1]}}, slope_r});
    end
  end

  // ---------------- channel blend, one channel per cycle
  logic [F:0]   w_bg, w_ln;
  logic [7:0]   b_ch, l_ch;
  logic [F+8:0] prod_bg, prod_ln;
  logic [8:0]   ch_sum;
  logic [7:0]   ch_val;

  always_comb begin
    unique case (ch_r)
      CH_RED: begin
        b_ch = in_r.bg_red;
        l_ch = colour_r[23:16];
      end
      CH_GREEN: begin
        b_ch = in_r.bg_green;
        l_ch = colour_r[15:8];
      end
      CH_BLUE: begin
        b_ch = in_r.bg_blue;
        l_ch = colour_r[7:0];
      end
      default: begin
        b_ch = in_r.bg_blue;
        l_ch = colour_r[7:0];
      end
    endcase
    // upper pixel weights background by the fraction, lower by its complement
    w_bg    = (phase_r == alr_pkg::PH_UPPER) ? {1'b0, m_frac} : ONE - {1'b0, m_frac};
    w_ln    = ONE - w_bg;
    prod_bg = (F+9)'(w_bg) * (F+9)'(b_ch);
    prod_ln = (F+9)'(w_ln) * (F+9)'(l_ch);
    ch_sum  = {1'b0, prod_bg[F+7:F]} + {1'b0, prod_ln[F+7:F]};
    ch_val  = ch_sum[8] ? 8'hFF : ch_sum[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= CH_RED;
    end else if (cmd.blend_step) begin
      ch_r <= (ch_r == CH_BLUE) ? CH_RED : ch_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.blend_step) begin
      blend_r[ch_r] <= ch_val;
    end
  end

  // ---------------- result formation
  logic              more_steps;
  logic              slot_free;
  logic              fire;
  logic [C-1:0]      mc;
  alr_pkg::alr_out_t od;

  assign more_steps = major_pos_r < {1'b0, major_stop_r};
  assign slot_free  = !out_valid_r || out_ready;
  assign fire       = cmd.emit && slot_free;

  always_comb begin
    od        = '0;
    phase_nxt = phase_r;
    mc        = m_int;
    unique case (cmd.emit_kind)
      alr_pkg::EM_START: begin
        od.access  = alr_pkg::ACC_WRITE;
        od.pixel_x = in_r.x_start;
        od.pixel_y = in_r.y_start;
        {od.out_red, od.out_green, od.out_blue} = colour_r;
      end
      alr_pkg::EM_PIXEL: begin
        mc         = (phase_r == alr_pkg::PH_UPPER) ? m_int : m_int + C'(1);
        od.access  = alr_pkg::ACC_WRITE;
        od.pixel_x = xdom_r ? major_pos_r[C-1:0] : mc;
        od.pixel_y = xdom_r ? mc : major_pos_r[C-1:0];
        od.out_red   = blend_r[CH_RED];
        od.out_green = blend_r[CH_GREEN];
        od.out_blue  = blend_r[CH_BLUE];
      end
      alr_pkg::EM_LOWER: begin
        mc              = m_int + C'(1);
        od.access       = alr_pkg::ACC_READ;
        od.pixel_x      = xdom_r ? major_pos_r[C-1:0] : mc;
        od.pixel_y      = xdom_r ? mc : major_pos_r[C-1:0];
        od.last_of_item = 1'b1;
        phase_nxt       = alr_pkg::PH_LOWER;
      end
      alr_pkg::EM_NEXT: begin
        od.last_of_item = 1'b1;
        if (more_steps) begin
          od.access  = alr_pkg::ACC_READ;
          od.pixel_x = xdom_r ? major_pos_r[C-1:0] : mc;
          od.pixel_y = xdom_r ? mc : major_pos_r[C-1:0];
          phase_nxt  = alr_pkg::PH_UPPER;
        end else begin
          od.access    = alr_pkg::ACC_WRITE;
          od.pixel_x   = end_point_r[C-1:0];
          od.pixel_y   = end_point_r[2*C-1:C];
          {od.out_red, od.out_green, od.out_blue} = colour_r;
          od.line_done = 1'b1;
          phase_nxt    = alr_pkg::PH_IDLE;
        end
      end
      default: od = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= alr_pkg::PH_IDLE;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= od;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.in_is_line = (in_data.command == alr_pkg::CMD_LINE);
  assign sts.line_busy  = (phase_r != alr_pkg::PH_IDLE);
  assign sts.slot_free  = slot_free;
  assign sts.div_done   = div_done;
  assign sts.blend_last = (ch_r == CH_BLUE);
  assign sts.lower_ok   = (phase_r == alr_pkg::PH_UPPER) && (m_int != {C{1'b1}});

endmodule
`default_nettype wire
